// File: hw/rtl/brb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_pkg
// Shared constants, action codes and control types of the byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

  // Buffer geometry. Depth must be a power of two so pointers wrap naturally.
  localparam int unsigned Depth    = 4096;
  localparam int unsigned AddrW    = $clog2(Depth);
  localparam int unsigned LenW     = 13;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ActW     = 3;
  localparam int unsigned MaxBurst = 64;
  localparam int unsigned BurstW   = $clog2(MaxBurst + 1);

  // Packed widths of the stream payloads.
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 48;

  // Action codes.
  localparam logic [ActW-1:0] ActWrite   = 3'd0;
  localparam logic [ActW-1:0] ActRead    = 3'd1;
  localparam logic [ActW-1:0] ActPeek    = 3'd2;
  localparam logic [ActW-1:0] ActExact   = 3'd3;
  localparam logic [ActW-1:0] ActDiscard = 3'd4;
  localparam logic [ActW-1:0] ActStatus  = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic exec;
    logic rd_issue;
    logic emit;
  } brb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_burst;
    logic out_free;
    logic last_byte;
  } brb_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/brb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_ctrl
// Sequencer that accepts one item, runs its action and streams burst bytes.
// ----------------------------------------------------------------------------
module brb_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire brb_pkg::brb_stat_t stat_i,
  output brb_pkg::brb_cmd_t       cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0] state_q;
  logic [1:0] state_d;

  assign s_axis_tready = (state_q == StIdle);

  // Next state and command decode.
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.latch_in = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          cmd_o.latch_in = 1'b1;
          state_d        = StExec;
        end
      end
      StExec: begin
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          if (stat_i.is_burst) begin
            cmd_o.rd_issue = 1'b1;
            state_d        = StEmit;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StEmit: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.last_byte) begin
            state_d = StIdle;
          end else begin
            cmd_o.rd_issue = 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  // A result is only pushed into the output register when it has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.exec || cmd_o.emit) |-> stat_i.out_free)
    else $error("brb_ctrl: result loaded into a full output register");

  // A burst always begins with a read of its first byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && $past(state_q) == StExec) |-> $past(cmd_o.rd_issue))
    else $error("brb_ctrl: burst entered without a first read");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/brb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brb_datapath
// Byte store, pointers, full flag, action decode and the output register.
// ----------------------------------------------------------------------------
module brb_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire brb_pkg::brb_cmd_t                 cmd_i,
  output brb_pkg::brb_stat_t                     stat_o,
  // Fields from bit 0 up: action, data_in, length.
  input  wire logic [brb_pkg::InDataW-1:0]       s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // Fields from bit 0 up: data_out, count, used_length, free_length, zero pad.
  output logic [brb_pkg::OutDataW-1:0]           m_axis_tdata,
  output logic                                   m_axis_tlast,
  // Field: status.
  output logic                                   m_axis_tuser
);

  localparam int unsigned AW = brb_pkg::AddrW;
  localparam int unsigned LW = brb_pkg::LenW;
  localparam int unsigned BW = brb_pkg::BurstW;
  localparam int unsigned DW = brb_pkg::ByteW;

  // Latched item.
  logic [brb_pkg::ActW-1:0] act_q;
  logic [DW-1:0]            din_q;
  logic [LW-1:0]            len_q;

  // Buffer state.
  logic [AW-1:0] rp_q, rp_d;
  logic [AW-1:0] wp_q, wp_d;
  logic          full_q, full_d;

  // Burst state.
  logic [AW-1:0] bptr_q;
  logic [BW-1:0] idx_q;
  logic [BW-1:0] k_q;

  // Byte store.
  logic [DW-1:0] mem [brb_pkg::Depth];
  logic [DW-1:0] rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] raddr;

  // Output register.
  logic          out_valid_q;
  logic [DW-1:0] out_data_q;
  logic          out_last_q;
  logic [LW-1:0] out_count_q;
  logic          out_status_q;
  logic [LW-1:0] out_used_q;
  logic [LW-1:0] out_free_q;

  // Decode results.
  logic [AW-1:0] used_diff;
  logic [LW-1:0] used;
  logic          empty;
  logic [BW-1:0] n;
  logic [BW-1:0] k;
  logic          is_burst;
  logic [LW-1:0] res_count;
  logic          res_status;
  logic [AW-1:0] wbase;
  logic [AW-1:0] used_nx_diff;
  logic [LW-1:0] used_nx;
  logic [LW-1:0] used_out;
  logic          out_free;
  logic          out_load;

  // Fill level from the current pointers; the pointer difference wraps.
  assign used_diff = wp_q - rp_q;
  assign used      = full_q ? LW'(brb_pkg::Depth) : {1'b0, used_diff};
  assign empty     = (used == '0);

  // Clamp the request to the burst limit and to the bytes held.
  assign n = (len_q > LW'(brb_pkg::MaxBurst)) ? BW'(brb_pkg::MaxBurst) : BW'(len_q);
  assign k = (LW'(n) < used) ? n : BW'(used);

  assign wbase = empty ? '0 : wp_q;

  // Action decode: next pointers and the single-result fields.
  always_comb begin
    rp_d       = rp_q;
    wp_d       = wp_q;
    full_d     = full_q;
    mem_we     = 1'b0;
    mem_waddr  = wbase;
    is_burst   = 1'b0;
    res_count  = '0;
    res_status = 1'b0;
    unique case (act_q)
      brb_pkg::ActWrite: begin
        if (full_q) begin
          res_status = 1'b1;
        end else begin
          mem_we    = cmd_i.exec;
          wp_d      = wbase + AW'(1);
          rp_d      = empty ? '0 : rp_q;
          full_d    = ((wbase + AW'(1)) == (empty ? '0 : rp_q));
          res_count = LW'(1);
        end
      end
      brb_pkg::ActRead, brb_pkg::ActPeek, brb_pkg::ActExact: begin
        if (empty || (act_q == brb_pkg::ActExact && used < LW'(n))) begin
          res_status = 1'b1;
        end else if (n == '0) begin
          res_status = 1'b0;
        end else begin
          is_burst  = 1'b1;
          res_count = LW'(k);
          if (act_q != brb_pkg::ActPeek) begin
            if (LW'(k) == used) begin
              rp_d   = '0;
              wp_d   = '0;
              full_d = 1'b0;
            end else begin
              rp_d   = rp_q + AW'(k);
              full_d = 1'b0;
            end
          end
        end
      end
      brb_pkg::ActDiscard: begin
        if (len_q == '0) begin
          rp_d   = '0;
          wp_d   = '0;
          full_d = 1'b0;
        end else if (empty) begin
          res_status = 1'b1;
        end else if (len_q >= used) begin
          rp_d      = '0;
          wp_d      = '0;
          full_d    = 1'b0;
          res_count = used;
        end else begin
          rp_d      = rp_q + len_q[AW-1:0];
          full_d    = 1'b0;
          res_count = len_q;
        end
      end
      default: begin
        res_status = 1'b0;
      end
    endcase
  end

  // Fill level after the action, for single-result items.
  assign used_nx_diff = wp_d - rp_d;
  assign used_nx      = full_d ? LW'(brb_pkg::Depth) : {1'b0, used_nx_diff};

  // Burst bytes report the live level, which the action already updated.
  assign used_out = cmd_i.emit ? used : used_nx;

  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = (cmd_i.exec && !is_burst) || cmd_i.emit;

  assign stat_o.is_burst  = is_burst;
  assign stat_o.out_free  = out_free;
  assign stat_o.last_byte = (idx_q == (k_q - BW'(1)));

  assign raddr = cmd_i.exec ? rp_q : bptr_q;

  // Item latch.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      act_q <= s_axis_tdata[2:0];
      din_q <= s_axis_tdata[10:3];
      len_q <= s_axis_tdata[23:11];
    end
  end

  // Pointers and full flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q   <= '0;
      wp_q   <= '0;
      full_q <= 1'b0;
    end else if (cmd_i.exec) begin
      rp_q   <= rp_d;
      wp_q   <= wp_d;
      full_q <= full_d;
    end
  end

  // Burst tracking: read address, byte index and burst length.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bptr_q <= '0;
      idx_q  <= '0;
      k_q    <= '0;
    end else begin
      if (cmd_i.rd_issue) begin
        bptr_q <= raddr + AW'(1);
      end
      if (cmd_i.exec) begin
        idx_q <= '0;
        k_q   <= k;
      end else if (cmd_i.emit) begin
        idx_q <= idx_q + BW'(1);
      end
    end
  end

  // Byte store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= din_q;
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= mem[raddr];
    end
  end

  // Output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q   <= cmd_i.emit ? rdata_q : '0;
      out_last_q   <= cmd_i.emit ? stat_o.last_byte : 1'b1;
      out_count_q  <= cmd_i.emit ? LW'(k_q) : res_count;
      out_status_q <= cmd_i.emit ? 1'b0 : res_status;
      out_used_q   <= used_out;
      out_free_q   <= LW'(brb_pkg::Depth) - used_out;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {1'b0, out_free_q, out_used_q, out_count_q, out_data_q};

`ifndef SYNTHESIS
  // Equal pointers with a clear full flag means empty, and empty always
  // means both pointers were returned to the start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!full_q && wp_q == rp_q) |-> (rp_q == '0 && wp_q == '0))
    else $error("brb_datapath: empty buffer with pointers off zero");

  // A full buffer has its pointers together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> (wp_q == rp_q))
    else $error("brb_datapath: full flag set with pointers apart");

  // Every emitted byte lies inside a nonempty burst.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (k_q != '0 && idx_q < k_q))
    else $error("brb_datapath: byte emitted outside its burst");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/byte_ring_buffer.sv
// Sequence: an item is accepted while idle; in the exec state a single-result
// action loads the output register and a burst reads its first byte from the
// registered read port of the byte store, then gives one byte per cycle while
// the output register has room. No new item is taken until the last is done.
// Reset: asynchronous, active low; pointers, full flag and control clear at
// once; the byte store is not cleared and holds no valid data until written.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_buffer
// Circular byte buffer with write, read, peek, exact read, discard and status.
// ----------------------------------------------------------------------------
module byte_ring_buffer (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0 up: action, data_in, length.
  input  wire logic [brb_pkg::InDataW-1:0] s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // Fields from bit 0 up: data_out, count, used_length, free_length, zero pad.
  output logic [brb_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                             m_axis_tlast,
  // Field: status.
  output logic                             m_axis_tuser
);

  brb_pkg::brb_cmd_t  cmd;
  brb_pkg::brb_stat_t stat;

  // Action sequencer.
  brb_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // Storage, pointers and result register.
  brb_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
`default_nettype wire
